@@ hw/rtl/ritab_pkg.sv @@
// Package for the reference-counted inode table: sizes, codes and shared types.
// No dependencies; imported by every module of the block.
package ritab_pkg;

  localparam int SLOTS        = 64;
  localparam int BLOCK_INODES = 8;

  localparam int SLOT_IW  = $clog2(SLOTS);
  localparam int SCAN_W   = SLOT_IW + 1;
  localparam int INODE_W  = 16;
  localparam int COUNT_W  = 8;
  localparam int BASE_W   = 24;
  localparam int BLOCK_W  = 25;
  localparam int OFF_W    = 6;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 4;
  localparam int KIND_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIRTY   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

  localparam logic [STATUS_W-1:0] RS_HIT       = 4'd0;
  localparam logic [STATUS_W-1:0] RS_LOADED    = 4'd1;
  localparam logic [STATUS_W-1:0] RS_FULL      = 4'd2;
  localparam logic [STATUS_W-1:0] RS_STILL     = 4'd3;
  localparam logic [STATUS_W-1:0] RS_FREED     = 4'd4;
  localparam logic [STATUS_W-1:0] RS_WRITEBACK = 4'd5;
  localparam logic [STATUS_W-1:0] RS_MARKED    = 4'd6;
  localparam logic [STATUS_W-1:0] RS_IDLE_SLOT = 4'd7;
  localparam logic [STATUS_W-1:0] RS_SAT       = 4'd8;

  typedef struct packed {
    logic [INODE_W-1:0] inode;
    logic [COUNT_W-1:0] count;
    logic               dirty;
  } entry_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_IW-1:0] waddr;
    entry_t             wdata;
    logic [SLOT_IW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               start;
    logic [INODE_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [INODE_W-1:0] quo;
    logic [OFF_W-1:0]   rem;
  } div_rsp_t;

endpackage

@@ hw/rtl/ritab_mem.sv @@
// Slot memory: one entry per slot, one write and one registered read per cycle.
// Per-slot valid flops make unwritten slots read as zero after reset. Uses ritab_pkg.
module ritab_mem import ritab_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  entry_t           rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[req.raddr];
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

@@ hw/rtl/ritab_div.sv @@
// Block/offset split of an inode index by the constant inodes-per-disk-block.
// The divisor is a power of two, so this is a shift and a mask; the result is
// registered and valid in the cycle after start. Uses ritab_pkg.
module ritab_div import ritab_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [INODE_W-1:0] DIVISOR = INODE_W'(BLOCK_INODES);

  logic               done_r;
  logic [INODE_W-1:0] quo_r;
  logic [OFF_W-1:0]   rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= req.start;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend / DIVISOR;
      rem_r <= OFF_W'(req.dividend % DIVISOR);
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ hw/rtl/refcounted_inode_table.sv @@
// Top level of the reference-counted inode table: sequencer, result register.
// Instantiates ritab_mem and ritab_div; uses ritab_pkg.
//
// Input words (in_valid/in_ready) carry kind, inode number and slot. Acquire
// searches the slot table for a live slot with that inode number, else takes
// the lowest free slot; release and mark-dirty act on the named slot. Each
// word of kind 0..2 gives one result word on out_valid/out_ready; kind 3 is
// dropped. cfg_we/cfg_wdata set the on-disk inode table base block; the user must
// see that it is written only while the block is idle: the block does not enforce it.
// One word is in work at a time; in_ready is high only while idle. The slot
// memory is read once a cycle, so an acquire reads the slots in order from
// slot 0 and stops at the first hit or after the last slot. A load also
// goes through the block/offset split before its result. Release and
// mark-dirty read the named slot and then update it; a write-back release
// also goes through the split. The next word can be taken in the cycle after
// the result is loaded.
// The result register frees the sequencer, so the next word is taken while a
// result waits; a held result stalls only the following completion.
// Synchronous reset empties all slots at once (valid flops), clears the base
// register and drops any result; no clearing pass is needed.
module refcounted_inode_table import ritab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [BASE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [INODE_W-1:0]   in_inode_number,
  input  logic [SLOT_W-1:0]    in_slot,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [SLOT_W-1:0]    out_result_slot,
  output logic [BLOCK_W-1:0]   out_disk_block,
  output logic [OFF_W-1:0]     out_block_offset,
  output logic [COUNT_W-1:0]   out_count_after
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_ACT  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(SLOTS);
  localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(SLOTS - 1);

  logic [2:0]          state_r, state_nxt;
  logic [BASE_W-1:0]   base_r;

  // word in work
  logic [KIND_W-1:0]   kind_r;
  logic [INODE_W-1:0]  inode_r;
  logic [SLOT_IW-1:0]  slot_r;

  // scan pointers
  logic [SCAN_W-1:0]   iss_r, iss_nxt;
  logic [SLOT_IW-1:0]  chk_r, chk_nxt;
  logic                pend_r, pend_nxt;
  logic                free_found_r, free_found_nxt;
  logic [SLOT_IW-1:0]  free_idx_r, free_idx_nxt;

  // result being built
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [BLOCK_W-1:0]  res_block_r, res_block_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;
  logic [COUNT_W-1:0]  res_count_r, res_count_nxt;

  logic                out_valid_r;
  logic                out_load;

  mem_req_t            mreq;
  entry_t              rd_data;
  div_req_t            dreq;
  div_rsp_t            drsp;

  logic                in_acc;
  logic                slot_oob;
  logic                hit;
  logic                last_chk;
  logic [COUNT_W-1:0]  cnt_dec;

  ritab_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .rd_data (rd_data)
  );

  ritab_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign slot_oob = ({3'b000, in_slot} >= 9'(SLOTS));
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign hit      = pend_r && (rd_data.count != '0) && (rd_data.inode == inode_r);
  assign last_chk = pend_r && (chk_r == LAST_SLOT);
  assign cnt_dec  = rd_data.count - 1'b1;

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    chk_nxt        = chk_r;
    pend_nxt       = 1'b0;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_block_nxt  = res_block_r;
    res_off_nxt    = res_off_r;
    res_count_nxt  = res_count_r;
    mreq.we        = 1'b0;
    mreq.waddr     = slot_r;
    mreq.wdata     = rd_data;
    mreq.raddr     = SLOT_IW'(in_slot);
    dreq.start     = 1'b0;
    dreq.dividend  = inode_r - 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        res_block_nxt = '0;
        res_off_nxt   = '0;
        res_slot_nxt  = in_slot;
        res_count_nxt = '0;
        if (in_acc) begin
          case (in_kind)
            KIND_ACQUIRE: begin
              state_nxt      = ST_SCAN;
              iss_nxt        = '0;
              free_found_nxt = 1'b0;
            end
            KIND_RELEASE, KIND_DIRTY: begin
              if (slot_oob) begin
                res_status_nxt = (in_kind == KIND_RELEASE) ? RS_IDLE_SLOT : RS_MARKED;
                state_nxt      = ST_FIN;
              end else begin
                state_nxt = ST_ACT;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        // read slot iss_r; the data for chk_r arrives in the next cycle
        mreq.raddr = iss_r[SLOT_IW-1:0];
        if (iss_r < SCAN_END) begin
          pend_nxt = 1'b1;
          chk_nxt  = iss_r[SLOT_IW-1:0];
          iss_nxt  = iss_r + 1'b1;
        end
        if (pend_r && rd_data.count == '0 && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_r;
        end
        if (hit) begin
          pend_nxt     = 1'b0;
          res_slot_nxt = SLOT_W'(chk_r);
          state_nxt    = ST_FIN;
          if (rd_data.count == COUNT_MAX) begin
            res_status_nxt = RS_SAT;
            res_count_nxt  = COUNT_MAX;
          end else begin
            res_status_nxt    = RS_HIT;
            res_count_nxt     = rd_data.count + 1'b1;
            mreq.we           = 1'b1;
            mreq.waddr        = chk_r;
            mreq.wdata.count  = rd_data.count + 1'b1;
          end
        end else if (last_chk) begin
          pend_nxt = 1'b0;
          if (free_found_r || rd_data.count == '0) begin
            mreq.we          = 1'b1;
            mreq.waddr       = free_found_r ? free_idx_r : chk_r;
            mreq.wdata.inode = inode_r;
            mreq.wdata.count = COUNT_W'(1);
            mreq.wdata.dirty = 1'b0;
            res_status_nxt   = RS_LOADED;
            res_slot_nxt     = SLOT_W'(free_found_r ? free_idx_r : chk_r);
            res_count_nxt    = COUNT_W'(1);
            dreq.start       = 1'b1;
            state_nxt        = ST_DIV;
          end else begin
            res_status_nxt = RS_FULL;
            res_slot_nxt   = '0;
            state_nxt      = ST_FIN;
          end
        end
      end

      ST_ACT: begin
        state_nxt  = ST_FIN;
        mreq.waddr = slot_r;
        if (kind_r == KIND_RELEASE) begin
          if (rd_data.count == '0) begin
            res_status_nxt = RS_IDLE_SLOT;
          end else begin
            mreq.we          = 1'b1;
            mreq.wdata.count = cnt_dec;
            res_count_nxt    = cnt_dec;
            if (cnt_dec != '0) begin
              res_status_nxt = RS_STILL;
            end else if (rd_data.dirty) begin
              res_status_nxt = RS_WRITEBACK;
              dreq.start     = 1'b1;
              dreq.dividend  = rd_data.inode - 1'b1;
              state_nxt      = ST_DIV;
            end else begin
              res_status_nxt = RS_FREED;
            end
          end
        end else begin
          mreq.we          = 1'b1;
          mreq.wdata.dirty = 1'b1;
          res_status_nxt   = RS_MARKED;
          res_count_nxt    = rd_data.count;
        end
      end

      ST_DIV: begin
        if (drsp.done) begin
          res_block_nxt = {1'b0, base_r} + BLOCK_W'(drsp.quo);
          res_off_nxt   = drsp.rem;
          state_nxt     = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_kind;
      inode_r <= in_inode_number;
      slot_r  <= SLOT_IW'(in_slot);
    end
    iss_r        <= iss_nxt;
    chk_r        <= chk_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_block_r  <= res_block_nxt;
    res_off_r    <= res_off_nxt;
    res_count_r  <= res_count_nxt;
    if (out_load) begin
      out_status       <= res_status_r;
      out_result_slot  <= res_slot_r;
      out_disk_block   <= res_block_r;
      out_block_offset <= res_off_r;
      out_count_after  <= res_count_r;
    end
  end

  assign out_valid = out_valid_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside its wait state");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> iss_r <= SCAN_END)
    else $error("scan pointer ran past the table");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= RS_SAT)
    else $error("result status out of range");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == RS_LOADED) |-> out_count_after == COUNT_W'(1))
    else $error("loaded slot without a count of one");

endmodule
